[rtl/gvc_pkg.sv]
package gvc_pkg;

	localparam int ID_W       = 6;   // vertex id width
	localparam int ENDS_W     = 2 * ID_W;
	localparam int ID_WIDE_W  = 8;   // room for any vertex address up to 256 entries
	localparam int DEG_W      = 7;   // degree width
	localparam int ALU_W      = 8;   // degree sums need one bit more
	localparam int NV_W       = 7;   // num_vertices register width
	localparam int NV_RESET   = 64;
	localparam int EDGE_CAP_DEF = 32;
	localparam int VERT_CAP_DEF = 64;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB_SAT
	} alu_op_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} deg_ctl_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic dis;
		logic clr;
	} edge_ctl_t;

endpackage

[rtl/gvc_alu.sv]
module gvc_alu (
	input  gvc_pkg::alu_op_t           op,
	input  logic [gvc_pkg::ALU_W-1:0]  a,
	input  logic [gvc_pkg::ALU_W-1:0]  b,
	output logic [gvc_pkg::ALU_W-1:0]  y
);

	always_comb begin
		case (op)
			gvc_pkg::ALU_ADD: begin
				y = a + b;
			end
			gvc_pkg::ALU_SUB_SAT: begin
				y = (a >= b) ? (a - b) : '0;
			end
			default: begin
				y = '0;
			end
		endcase
	end

endmodule

[rtl/gvc_deg_mem.sv]
module gvc_deg_mem #(
	parameter int VERTEX_CAPACITY = gvc_pkg::VERT_CAP_DEF,
	localparam int VA = $clog2(VERTEX_CAPACITY)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gvc_pkg::deg_ctl_t          ctl,
	input  logic [VA-1:0]              ra_a,
	input  logic [VA-1:0]              ra_b,
	input  logic [VA-1:0]              wa,
	input  logic [gvc_pkg::DEG_W-1:0]  wd,
	output logic [gvc_pkg::DEG_W-1:0]  rd_a,
	output logic [gvc_pkg::DEG_W-1:0]  rd_b
);

	logic [gvc_pkg::DEG_W-1:0] mem [VERTEX_CAPACITY];
	logic [VERTEX_CAPACITY-1:0] valid_q;
	logic [gvc_pkg::DEG_W-1:0] rd_a_q;
	logic [gvc_pkg::DEG_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wa] <= wd;
		end
		// entries not written since the last clear read as zero
		if (ctl.rd) begin
			rd_a_q <= valid_q[ra_a] ? mem[ra_a] : '0;
			rd_b_q <= valid_q[ra_b] ? mem[ra_b] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr) begin
			valid_q <= '0;
		end else if (ctl.wr) begin
			valid_q[wa] <= 1'b1;
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

[rtl/gvc_edge_mem.sv]
module gvc_edge_mem #(
	parameter int EDGE_CAPACITY = gvc_pkg::EDGE_CAP_DEF,
	localparam int EA = $clog2(EDGE_CAPACITY)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gvc_pkg::edge_ctl_t          ctl,
	input  logic [EA-1:0]               wa,
	input  logic [gvc_pkg::ENDS_W-1:0]  wd,
	input  logic [EA-1:0]               ra,
	input  logic [EA-1:0]               da,
	output logic [gvc_pkg::ENDS_W-1:0]  rd_ends,
	output logic                        rd_en,
	output logic                        any_en
);

	logic [gvc_pkg::ENDS_W-1:0] mem [EDGE_CAPACITY];
	logic [EDGE_CAPACITY-1:0] en_q;
	logic [gvc_pkg::ENDS_W-1:0] rd_ends_q;
	logic rd_en_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wa] <= wd;
		end
		if (ctl.rd) begin
			rd_ends_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= '0;
			rd_en_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				en_q <= '0;
			end else begin
				if (ctl.wr) begin
					en_q[wa] <= 1'b1;
				end
				if (ctl.dis) begin
					en_q[da] <= 1'b0;
				end
			end
			if (ctl.rd) begin
				rd_en_q <= en_q[ra];
			end
		end
	end

	assign rd_ends = rd_ends_q;
	assign rd_en   = rd_en_q;
	assign any_en  = |en_q;

endmodule

[rtl/greedy_vertex_cover.sv]
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    u_vertex, v_vertex, last_edge
// out       out  out_valid/out_ready  cover_vertex, error, last
// cfg       in   cfg_wr_en            cfg_wr_data (num_vertices)
//
// A non-final edge passes LD_U and LD_V (LD_U only for a self-loop); a bad edge goes to
// its error result. The final edge starts the cover run: each pick is a scan (SC_ADDR,
// SC_EDGE, SC_CMP if enabled) and a disable pass (DS_ADDR, DS_EDGE, DS_WU/WV on a hit)
// per stored edge and two results, on one degree memory port pair and one shared adder.
// Output stalls hold the sequencer. Reset clears the degree valid bits at once; no sweep.
module greedy_vertex_cover #(
	parameter int EDGE_CAPACITY   = gvc_pkg::EDGE_CAP_DEF,
	parameter int VERTEX_CAPACITY = gvc_pkg::VERT_CAP_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [gvc_pkg::NV_W-1:0]   cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [gvc_pkg::ID_W-1:0]   u_vertex,
	input  logic [gvc_pkg::ID_W-1:0]   v_vertex,
	input  logic                       last_edge,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [gvc_pkg::ID_W-1:0]   cover_vertex,
	output logic                       error,
	output logic                       last
);

	localparam int EA = $clog2(EDGE_CAPACITY);
	localparam int CW = $clog2(EDGE_CAPACITY + 1);
	localparam int VA = $clog2(VERTEX_CAPACITY);
	localparam int IW = gvc_pkg::ID_W;
	localparam int AW = gvc_pkg::ALU_W;
	localparam int DW = gvc_pkg::DEG_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_U,
		ST_LD_V,
		ST_SC_ADDR,
		ST_SC_EDGE,
		ST_SC_CMP,
		ST_DS_ADDR,
		ST_DS_EDGE,
		ST_DS_WU,
		ST_DS_WV,
		ST_EMIT_U,
		ST_EMIT_V,
		ST_EMIT_ERR
	} state_t;

	state_t state_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] u_q;
	logic [IW-1:0] v_q;
	logic          last_edge_q;
	logic [IW-1:0] eu_q;
	logic [IW-1:0] ev_q;
	logic [IW-1:0] bu_q;
	logic [IW-1:0] bv_q;
	logic [EA-1:0] best_q;
	logic [AW-1:0] best_sum_q;
	logic          found_q;
	logic [gvc_pkg::NV_W-1:0] nv_q;
	logic          out_valid_q;
	logic [IW-1:0] cover_q;
	logic          error_q;
	logic          last_q;

	gvc_pkg::deg_ctl_t  deg_ctl;
	gvc_pkg::edge_ctl_t edge_ctl;
	logic [VA-1:0] deg_ra_a;
	logic [VA-1:0] deg_ra_b;
	logic [VA-1:0] deg_wa;
	logic [DW-1:0] deg_wd;
	logic [DW-1:0] deg_a;
	logic [DW-1:0] deg_b;
	logic [gvc_pkg::ENDS_W-1:0] edge_rd_ends;
	logic edge_rd_en;
	logic any_en;
	logic [IW-1:0] rd_u;
	logic [IW-1:0] rd_v;

	gvc_pkg::alu_op_t alu_op;
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	logic [AW-1:0] alu_y;

	logic [CW-1:0] idx_nx;
	logic          idx_end;
	logic          bad_in;
	logic          hit;

	function automatic logic [VA-1:0] vaddr(input logic [IW-1:0] id);
		logic [gvc_pkg::ID_WIDE_W-1:0] w;
		w = gvc_pkg::ID_WIDE_W'(id);
		return w[VA-1:0];
	endfunction

	assign rd_u    = edge_rd_ends[2*IW-1:IW];
	assign rd_v    = edge_rd_ends[IW-1:0];
	assign idx_nx  = idx_q + 1'b1;
	assign idx_end = (idx_nx == cnt_q);

	assign bad_in = ({1'b0, u_vertex} >= nv_q) || ({1'b0, v_vertex} >= nv_q) ||
		(9'(u_vertex) >= 9'(VERTEX_CAPACITY)) || (9'(v_vertex) >= 9'(VERTEX_CAPACITY)) ||
		(cnt_q >= CW'(EDGE_CAPACITY));

	assign hit = edge_rd_en && ((idx_q[EA-1:0] == best_q) || (rd_u == bu_q) ||
		(rd_u == bv_q) || (rd_v == bu_q) || (rd_v == bv_q));

	always_comb begin
		deg_ctl  = '0;
		edge_ctl = '0;
		deg_ra_a = vaddr(rd_u);
		deg_ra_b = vaddr(rd_v);
		deg_wa   = vaddr(u_q);
		deg_wd   = alu_y[DW-1:0];
		alu_op   = gvc_pkg::ALU_ADD;
		alu_a    = AW'(deg_a);
		alu_b    = AW'(deg_b);
		case (state_q)
			ST_IDLE: begin
				deg_ra_a = vaddr(u_vertex);
				deg_ra_b = vaddr(v_vertex);
				if (in_valid) begin
					deg_ctl.rd   = !bad_in;
					edge_ctl.wr  = !bad_in;
					deg_ctl.clr  = bad_in;
					edge_ctl.clr = bad_in;
				end
			end
			ST_LD_U: begin
				alu_b      = (u_q == v_q) ? AW'(2) : AW'(1);
				deg_wa     = vaddr(u_q);
				deg_ctl.wr = 1'b1;
			end
			ST_LD_V: begin
				alu_a      = AW'(deg_b);
				alu_b      = AW'(1);
				deg_wa     = vaddr(v_q);
				deg_ctl.wr = 1'b1;
			end
			ST_SC_ADDR, ST_DS_ADDR: begin
				edge_ctl.rd = 1'b1;
			end
			ST_SC_EDGE: begin
				deg_ctl.rd = 1'b1;
			end
			ST_DS_EDGE: begin
				deg_ctl.rd   = 1'b1;
				edge_ctl.dis = hit;
			end
			ST_DS_WU: begin
				alu_op     = gvc_pkg::ALU_SUB_SAT;
				alu_b      = (eu_q == ev_q) ? AW'(2) : AW'(1);
				deg_wa     = vaddr(eu_q);
				deg_ctl.wr = 1'b1;
			end
			ST_DS_WV: begin
				alu_op     = gvc_pkg::ALU_SUB_SAT;
				alu_a      = AW'(deg_b);
				alu_b      = AW'(1);
				deg_wa     = vaddr(ev_q);
				deg_ctl.wr = 1'b1;
			end
			ST_EMIT_V: begin
				if (out_ready && !any_en) begin
					deg_ctl.clr  = 1'b1;
					edge_ctl.clr = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	gvc_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	gvc_deg_mem #(
		.VERTEX_CAPACITY (VERTEX_CAPACITY)
	) u_deg_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (deg_ctl),
		.ra_a   (deg_ra_a),
		.ra_b   (deg_ra_b),
		.wa     (deg_wa),
		.wd     (deg_wd),
		.rd_a   (deg_a),
		.rd_b   (deg_b)
	);

	gvc_edge_mem #(
		.EDGE_CAPACITY (EDGE_CAPACITY)
	) u_edge_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (edge_ctl),
		.wa      (cnt_q[EA-1:0]),
		.wd      ({u_vertex, v_vertex}),
		.ra      (idx_q[EA-1:0]),
		.da      (idx_q[EA-1:0]),
		.rd_ends (edge_rd_ends),
		.rd_en   (edge_rd_en),
		.any_en  (any_en)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			u_q         <= '0;
			v_q         <= '0;
			last_edge_q <= 1'b0;
			eu_q        <= '0;
			ev_q        <= '0;
			bu_q        <= '0;
			bv_q        <= '0;
			best_q      <= '0;
			best_sum_q  <= '0;
			found_q     <= 1'b0;
			nv_q        <= gvc_pkg::NV_W'(gvc_pkg::NV_RESET);
			out_valid_q <= 1'b0;
			cover_q     <= '0;
			error_q     <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				nv_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (bad_in) begin
							cnt_q       <= '0;
							out_valid_q <= 1'b1;
							cover_q     <= '0;
							error_q     <= 1'b1;
							last_q      <= 1'b1;
							state_q     <= ST_EMIT_ERR;
						end else begin
							cnt_q       <= cnt_q + 1'b1;
							u_q         <= u_vertex;
							v_q         <= v_vertex;
							last_edge_q <= last_edge;
							state_q     <= ST_LD_U;
						end
					end
				end
				ST_LD_U, ST_LD_V: begin
					if (state_q == ST_LD_U && u_q != v_q) begin
						state_q <= ST_LD_V;
					end else if (last_edge_q) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_SC_ADDR;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SC_ADDR: begin
					state_q <= ST_SC_EDGE;
				end
				ST_SC_EDGE: begin
					eu_q <= rd_u;
					ev_q <= rd_v;
					if (edge_rd_en) begin
						state_q <= ST_SC_CMP;
					end else begin
						idx_q   <= idx_end ? '0 : idx_nx;
						state_q <= idx_end ? ST_DS_ADDR : ST_SC_ADDR;
					end
				end
				ST_SC_CMP: begin
					// strict compare keeps the lowest index on ties
					if (!found_q || alu_y > best_sum_q) begin
						found_q    <= 1'b1;
						best_q     <= idx_q[EA-1:0];
						best_sum_q <= alu_y;
						bu_q       <= eu_q;
						bv_q       <= ev_q;
					end
					idx_q   <= idx_end ? '0 : idx_nx;
					state_q <= idx_end ? ST_DS_ADDR : ST_SC_ADDR;
				end
				ST_DS_ADDR: begin
					state_q <= ST_DS_EDGE;
				end
				ST_DS_EDGE: begin
					eu_q <= rd_u;
					ev_q <= rd_v;
					if (hit) begin
						state_q <= ST_DS_WU;
					end else if (idx_end) begin
						out_valid_q <= 1'b1;
						cover_q     <= bu_q;
						error_q     <= 1'b0;
						last_q      <= 1'b0;
						state_q     <= ST_EMIT_U;
					end else begin
						idx_q   <= idx_nx;
						state_q <= ST_DS_ADDR;
					end
				end
				ST_DS_WU, ST_DS_WV: begin
					if (state_q == ST_DS_WU && eu_q != ev_q) begin
						state_q <= ST_DS_WV;
					end else if (idx_end) begin
						out_valid_q <= 1'b1;
						cover_q     <= bu_q;
						error_q     <= 1'b0;
						last_q      <= 1'b0;
						state_q     <= ST_EMIT_U;
					end else begin
						idx_q   <= idx_nx;
						state_q <= ST_DS_ADDR;
					end
				end
				ST_EMIT_U: begin
					if (out_ready) begin
						cover_q <= bv_q;
						last_q  <= !any_en;
						state_q <= ST_EMIT_V;
					end
				end
				ST_EMIT_V: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						idx_q       <= '0;
						found_q     <= 1'b0;
						if (any_en) begin
							state_q <= ST_SC_ADDR;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT_ERR: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign cover_vertex = cover_q;
	assign error        = error_q;
	assign last         = last_q;

endmodule
